@@ rtl/btfp_pkg.sv @@
package btfp_pkg;

    localparam int MAX_FRAME_DEF = 64;
    localparam int HEAD_KEEP_DEF = 34;
    localparam int CNT_W = 8;

    localparam logic [7:0] SOF_BYTE = 8'h6a;
    localparam logic [7:0] TYPE_STARTUP = 8'h2c;
    localparam logic [7:0] TYPE_TELEM = 8'h02;

    typedef enum logic [2:0] {
        KIND_IGNORED = 3'd0,
        KIND_SHORT_STARTUP = 3'd1,
        KIND_STARTUP = 3'd2,
        KIND_ACK = 3'd3,
        KIND_TELEM = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  frame_kind;
        logic        crc_ok;
        logic        send_handshake;
        logic [7:0]  resist_level;
        logic [7:0]  cadence_rpm;
        logic [15:0] speed_mm_s;
        logic [15:0] distance_raw;
        logic [15:0] energy_tenths;
        logic [7:0]  heart_bpm;
        logic [15:0] crank_count;
        logic [15:0] crank_time;
        logic [10:0] est_watts;
    } out_item_t;

    typedef struct packed {
        logic take_byte;
        logic start_finish;
        logic div_step;
        logic calc_step;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic last_byte;
        logic need_calc;
        logic div_done;
    } status_t;

    function automatic logic [12:0] power_entry(input logic [4:0] lvl, input logic [3:0] s);
        logic [12:0] r;
        begin
            r = 13'd0;
            case ({lvl, s})
                {5'd0,4'd1}: r = 10;   {5'd0,4'd2}: r = 22;   {5'd0,4'd3}: r = 48;
                {5'd0,4'd4}: r = 95;   {5'd0,4'd5}: r = 136;  {5'd0,4'd6}: r = 167;
                {5'd0,4'd7}: r = 226;  {5'd0,4'd8}: r = 263;  {5'd0,4'd9}: r = 292;
                {5'd0,4'd10}: r = 470;
                {5'd1,4'd1}: r = 13;   {5'd1,4'd2}: r = 30;   {5'd1,4'd3}: r = 54;
                {5'd1,4'd4}: r = 104;  {5'd1,4'd5}: r = 145;  {5'd1,4'd6}: r = 185;
                {5'd1,4'd7}: r = 246;  {5'd1,4'd8}: r = 276;  {5'd1,4'd9}: r = 335;
                {5'd1,4'd10}: r = 495;
                {5'd2,4'd1}: r = 15;   {5'd2,4'd2}: r = 37;   {5'd2,4'd3}: r = 67;
                {5'd2,4'd4}: r = 117;  {5'd2,4'd5}: r = 159;  {5'd2,4'd6}: r = 196;
                {5'd2,4'd7}: r = 261;  {5'd2,4'd8}: r = 308;  {5'd2,4'd9}: r = 352;
                {5'd2,4'd10}: r = 512;
                {5'd3,4'd1}: r = 16;   {5'd3,4'd2}: r = 47;   {5'd3,4'd3}: r = 75;
                {5'd3,4'd4}: r = 137;  {5'd3,4'd5}: r = 176;  {5'd3,4'd6}: r = 226;
                {5'd3,4'd7}: r = 290;  {5'd3,4'd8}: r = 369;  {5'd3,4'd9}: r = 426;
                {5'd3,4'd10}: r = 572;
                {5'd4,4'd1}: r = 18;   {5'd4,4'd2}: r = 52;   {5'd4,4'd3}: r = 80;
                {5'd4,4'd4}: r = 148;  {5'd4,4'd5}: r = 191;  {5'd4,4'd6}: r = 235;
                {5'd4,4'd7}: r = 325;  {5'd4,4'd8}: r = 375;  {5'd4,4'd9}: r = 508;
                {5'd4,4'd10}: r = 618;
                {5'd5,4'd1}: r = 19;   {5'd5,4'd2}: r = 57;   {5'd5,4'd3}: r = 87;
                {5'd5,4'd4}: r = 156;  {5'd5,4'd5}: r = 202;  {5'd5,4'd6}: r = 255;
                {5'd5,4'd7}: r = 335;  {5'd5,4'd8}: r = 396;  {5'd5,4'd9}: r = 521;
                {5'd5,4'd10}: r = 653;
                {5'd6,4'd1}: r = 20;   {5'd6,4'd2}: r = 62;   {5'd6,4'd3}: r = 95;
                {5'd6,4'd4}: r = 168;  {5'd6,4'd5}: r = 218;  {5'd6,4'd6}: r = 281;
                {5'd6,4'd7}: r = 370;  {5'd6,4'd8}: r = 428;  {5'd6,4'd9}: r = 578;
                {5'd6,4'd10}: r = 684;
                {5'd7,4'd1}: r = 21;   {5'd7,4'd2}: r = 68;   {5'd7,4'd3}: r = 108;
                {5'd7,4'd4}: r = 182;  {5'd7,4'd5}: r = 236;  {5'd7,4'd6}: r = 295;
                {5'd7,4'd7}: r = 400;  {5'd7,4'd8}: r = 476;  {5'd7,4'd9}: r = 605;
                {5'd7,4'd10}: r = 721;
                {5'd8,4'd1}: r = 22;   {5'd8,4'd2}: r = 73;   {5'd8,4'd3}: r = 115;
                {5'd8,4'd4}: r = 193;  {5'd8,4'd5}: r = 263;  {5'd8,4'd6}: r = 335;
                {5'd8,4'd7}: r = 453;  {5'd8,4'd8}: r = 518;  {5'd8,4'd9}: r = 667;
                {5'd8,4'd10}: r = 768;
                {5'd9,4'd1}: r = 24;   {5'd9,4'd2}: r = 79;   {5'd9,4'd3}: r = 127;
                {5'd9,4'd4}: r = 208;  {5'd9,4'd5}: r = 298;  {5'd9,4'd6}: r = 376;
                {5'd9,4'd7}: r = 522;  {5'd9,4'd8}: r = 562;  {5'd9,4'd9}: r = 735;
                {5'd9,4'd10}: r = 836;
                {5'd10,4'd1}: r = 26;  {5'd10,4'd2}: r = 85;  {5'd10,4'd3}: r = 135;
                {5'd10,4'd4}: r = 235; {5'd10,4'd5}: r = 336; {5'd10,4'd6}: r = 419;
                {5'd10,4'd7}: r = 551; {5'd10,4'd8}: r = 590; {5'd10,4'd9}: r = 786;
                {5'd10,4'd10}: r = 897;
                {5'd11,4'd1}: r = 27;  {5'd11,4'd2}: r = 91;  {5'd11,4'd3}: r = 142;
                {5'd11,4'd4}: r = 256; {5'd11,4'd5}: r = 354; {5'd11,4'd6}: r = 453;
                {5'd11,4'd7}: r = 573; {5'd11,4'd8}: r = 628; {5'd11,4'd9}: r = 813;
                {5'd11,4'd10}: r = 950;
                {5'd12,4'd1}: r = 29;  {5'd12,4'd2}: r = 96;  {5'd12,4'd3}: r = 168;
                {5'd12,4'd4}: r = 291; {5'd12,4'd5}: r = 375; {5'd12,4'd6}: r = 496;
                {5'd12,4'd7}: r = 625; {5'd12,4'd8}: r = 690; {5'd12,4'd9}: r = 847;
                {5'd12,4'd10}: r = 993;
                {5'd13,4'd1}: r = 30;  {5'd13,4'd2}: r = 100; {5'd13,4'd3}: r = 223;
                {5'd13,4'd4}: r = 312; {5'd13,4'd5}: r = 403; {5'd13,4'd6}: r = 518;
                {5'd13,4'd7}: r = 650; {5'd13,4'd8}: r = 700; {5'd13,4'd9}: r = 926;
                {5'd13,4'd10}: r = 1082;
                {5'd14,4'd1}: r = 32;  {5'd14,4'd2}: r = 104; {5'd14,4'd3}: r = 240;
                {5'd14,4'd4}: r = 366; {5'd14,4'd5}: r = 425; {5'd14,4'd6}: r = 563;
                {5'd14,4'd7}: r = 740; {5'd14,4'd8}: r = 850; {5'd14,4'd9}: r = 982;
                {5'd14,4'd10}: r = 1235;
                {5'd15,4'd1}: r = 35;  {5'd15,4'd2}: r = 109; {5'd15,4'd3}: r = 251;
                {5'd15,4'd4}: r = 385; {5'd15,4'd5}: r = 476; {5'd15,4'd6}: r = 654;
                {5'd15,4'd7}: r = 830; {5'd15,4'd8}: r = 930; {5'd15,4'd9}: r = 1148;
                {5'd15,4'd10}: r = 1368;
                {5'd16,4'd1}: r = 37;  {5'd16,4'd2}: r = 115; {5'd16,4'd3}: r = 260;
                {5'd16,4'd4}: r = 410; {5'd16,4'd5}: r = 532; {5'd16,4'd6}: r = 716;
                {5'd16,4'd7}: r = 900; {5'd16,4'd8}: r = 1000; {5'd16,4'd9}: r = 1217;
                {5'd16,4'd10}: r = 1492;
                {5'd17,4'd1}: r = 40;  {5'd17,4'd2}: r = 121; {5'd17,4'd3}: r = 275;
                {5'd17,4'd4}: r = 436; {5'd17,4'd5}: r = 560; {5'd17,4'd6}: r = 823;
                {5'd17,4'd7}: r = 1010; {5'd17,4'd8}: r = 1136; {5'd17,4'd9}: r = 1430;
                {5'd17,4'd10}: r = 1628;
                {5'd18,4'd1}: r = 42;  {5'd18,4'd2}: r = 127; {5'd18,4'd3}: r = 297;
                {5'd18,4'd4}: r = 467; {5'd18,4'd5}: r = 642; {5'd18,4'd6}: r = 879;
                {5'd18,4'd7}: r = 1092; {5'd18,4'd8}: r = 1289; {5'd18,4'd9}: r = 1540;
                {5'd18,4'd10}: r = 1723;
                {5'd19,4'd1}: r = 45;  {5'd19,4'd2}: r = 137; {5'd19,4'd3}: r = 320;
                {5'd19,4'd4}: r = 500; {5'd19,4'd5}: r = 718; {5'd19,4'd6}: r = 956;
                {5'd19,4'd7}: r = 1138; {5'd19,4'd8}: r = 1356; {5'd19,4'd9}: r = 1650;
                {5'd19,4'd10}: r = 1850;
                {5'd20,4'd1}: r = 47;  {5'd20,4'd2}: r = 149; {5'd20,4'd3}: r = 345;
                {5'd20,4'd4}: r = 542; {5'd20,4'd5}: r = 770; {5'd20,4'd6}: r = 1007;
                {5'd20,4'd7}: r = 1270; {5'd20,4'd8}: r = 1476; {5'd20,4'd9}: r = 1800;
                {5'd20,4'd10}: r = 2000;
                {5'd21,4'd1}: r = 50;  {5'd21,4'd2}: r = 158; {5'd21,4'd3}: r = 365;
                {5'd21,4'd4}: r = 583; {5'd21,4'd5}: r = 834; {5'd21,4'd6}: r = 1101;
                {5'd21,4'd7}: r = 1360; {5'd21,4'd8}: r = 1681; {5'd21,4'd9}: r = 1960;
                {5'd21,4'd10}: r = 2135;
                {5'd22,4'd1}: r = 56;  {5'd22,4'd2}: r = 170; {5'd22,4'd3}: r = 395;
                {5'd22,4'd4}: r = 643; {5'd22,4'd5}: r = 888; {5'd22,4'd6}: r = 1234;
                {5'd22,4'd7}: r = 1540; {5'd22,4'd8}: r = 1820; {5'd22,4'd9}: r = 2100;
                {5'd22,4'd10}: r = 2350;
                {5'd23,4'd1}: r = 61;  {5'd23,4'd2}: r = 182; {5'd23,4'd3}: r = 440;
                {5'd23,4'd4}: r = 707; {5'd23,4'd5}: r = 999; {5'd23,4'd6}: r = 1333;
                {5'd23,4'd7}: r = 1660; {5'd23,4'd8}: r = 1980; {5'd23,4'd9}: r = 2300;
                {5'd23,4'd10}: r = 2535;
                {5'd24,4'd1}: r = 68;  {5'd24,4'd2}: r = 194; {5'd24,4'd3}: r = 490;
                {5'd24,4'd4}: r = 790; {5'd24,4'd5}: r = 1088; {5'd24,4'd6}: r = 1472;
                {5'd24,4'd7}: r = 1850; {5'd24,4'd8}: r = 2170; {5'd24,4'd9}: r = 2552;
                {5'd24,4'd10}: r = 2780;
                {5'd25,4'd1}: r = 76;  {5'd25,4'd2}: r = 220; {5'd25,4'd3}: r = 548;
                {5'd25,4'd4}: r = 880; {5'd25,4'd5}: r = 1270; {5'd25,4'd6}: r = 1670;
                {5'd25,4'd7}: r = 2120; {5'd25,4'd8}: r = 2440; {5'd25,4'd9}: r = 2870;
                {5'd25,4'd10}: r = 3050;
                {5'd26,4'd1}: r = 87;  {5'd26,4'd2}: r = 260; {5'd26,4'd3}: r = 620;
                {5'd26,4'd4}: r = 1000; {5'd26,4'd5}: r = 1450; {5'd26,4'd6}: r = 1900;
                {5'd26,4'd7}: r = 2420; {5'd26,4'd8}: r = 2810; {5'd26,4'd9}: r = 3151;
                {5'd26,4'd10}: r = 3500;
                {5'd27,4'd1}: r = 92;  {5'd27,4'd2}: r = 300; {5'd27,4'd3}: r = 710;
                {5'd27,4'd4}: r = 1144; {5'd27,4'd5}: r = 1616; {5'd27,4'd6}: r = 2151;
                {5'd27,4'd7}: r = 2751; {5'd27,4'd8}: r = 3170; {5'd27,4'd9}: r = 3585;
                {5'd27,4'd10}: r = 3900;
                {5'd28,4'd1}: r = 98;  {5'd28,4'd2}: r = 360; {5'd28,4'd3}: r = 825;
                {5'd28,4'd4}: r = 1345; {5'd28,4'd5}: r = 1953; {5'd28,4'd6}: r = 2525;
                {5'd28,4'd7}: r = 3137; {5'd28,4'd8}: r = 3600; {5'd28,4'd9}: r = 4203;
                {5'd28,4'd10}: r = 4600;
                {5'd29,4'd1}: r = 105; {5'd29,4'd2}: r = 430; {5'd29,4'd3}: r = 950;
                {5'd29,4'd4}: r = 1571; {5'd29,4'd5}: r = 2284; {5'd29,4'd6}: r = 3001;
                {5'd29,4'd7}: r = 3741; {5'd29,4'd8}: r = 4038; {5'd29,4'd9}: r = 4878;
                {5'd29,4'd10}: r = 5400;
                {5'd30,4'd1}: r = 125; {5'd30,4'd2}: r = 480; {5'd30,4'd3}: r = 993;
                {5'd30,4'd4}: r = 1622; {5'd30,4'd5}: r = 2329; {5'd30,4'd6}: r = 3104;
                {5'd30,4'd7}: r = 4003; {5'd30,4'd8}: r = 4355; {5'd30,4'd9}: r = 5305;
                {5'd30,4'd10}: r = 5890;
                {5'd31,4'd1}: r = 130; {5'd31,4'd2}: r = 530; {5'd31,4'd3}: r = 1020;
                {5'd31,4'd4}: r = 1703; {5'd31,4'd5}: r = 2420; {5'd31,4'd6}: r = 3200;
                {5'd31,4'd7}: r = 4279; {5'd31,4'd8}: r = 4752; {5'd31,4'd9}: r = 5700;
                {5'd31,4'd10}: r = 6250;
                default: r = 13'd0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/btfp_ctrl.sv @@
module btfp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output btfp_pkg::cmd_t      cmd,
    input  btfp_pkg::status_t   status
);
    import btfp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_DIVIDE,
        S_CALC,
        S_PUBLISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // The input is taken only while idle; a waiting result is held in the output register.
    assign in_ready  = (state_reg == S_IDLE) && !(out_valid_reg && status.last_byte);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.take_byte = 1'b1;
                    if (status.last_byte)
                    begin
                        state_next = S_CLASSIFY;
                    end
                end
            end
            S_CLASSIFY:
            begin
                cmd.start_finish = 1'b1;
                state_next = status.need_calc ? S_DIVIDE : S_PUBLISH;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc_step = 1'b1;
                state_next = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/btfp_datapath.sv @@
module btfp_datapath #(
    parameter int MAX_FRAME = btfp_pkg::MAX_FRAME_DEF,
    parameter int HEAD_KEEP = btfp_pkg::HEAD_KEEP_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  btfp_pkg::in_item_t   in_item,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  btfp_pkg::cmd_t       cmd,
    output btfp_pkg::status_t    status,
    output btfp_pkg::out_item_t  out_item
);
    import btfp_pkg::*;

    localparam int HIDX_W = $clog2(HEAD_KEEP);

    logic [7:0]       head_mem [HEAD_KEEP];
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       xor_reg;
    logic [7:0]       tail0_reg, tail1_reg;
    logic             legacy_reg, hs_done_reg, est_en_reg;
    logic [15:0]      crank_acc_reg;

    logic [2:0]       kind_reg;
    logic             crc_reg, send_hs_reg;
    logic [7:0]       cad_reg, res_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      quot_reg;
    logic [4:0]       div_cnt_reg;
    logic [10:0]      watts_reg;
    logic [12:0]      t_lo_reg, t_hi_reg;
    logic [20:0]      wnum_reg;
    logic             wbig_reg, wzero_reg;
    out_item_t        out_reg;

    logic             sof_ok, is_start, is_ack, is_tel;
    logic [CNT_W-1:0] count_inc;
    logic [16:0]      trial;
    logic [4:0]       lvl;
    logic [3:0]       s_idx, c_mod;
    logic [12:0]      t_lo, t_hi;
    logic signed [18:0] num;
    logic [20:0]      big_prod;
    logic [20:0]      wnum_calc;
    logic [42:0]      big_q;
    logic [33:0]      small_q;
    logic [10:0]      watts_calc;
    out_item_t        pub_item;

    assign status.last_byte = in_item.frame_last;
    assign status.need_calc = is_tel;
    assign status.div_done = (div_cnt_reg == 5'd16) || (cad_reg == 8'd0);

    assign count_inc = (count_reg >= CNT_W'(MAX_FRAME)) ? CNT_W'(MAX_FRAME) : count_reg + 1'b1;

    assign sof_ok = head_mem[0] == SOF_BYTE;
    assign is_start = (count_reg >= CNT_W'(4)) && sof_ok && (head_mem[3] == TYPE_STARTUP);
    assign is_ack = legacy_reg && (count_reg == CNT_W'(8)) && sof_ok
        && head_mem[1] == 8'h06 && head_mem[2] == 8'hb0 && head_mem[3] == 8'h1b
        && head_mem[4] == 8'h01 && head_mem[5] == 8'h00 && head_mem[6] == 8'hac
        && head_mem[7] == 8'h43;
    assign is_tel = !is_start && !is_ack && legacy_reg && (count_reg >= CNT_W'(28)) && sof_ok
        && (head_mem[3] == TYPE_TELEM);

    assign trial = {rem_reg, quot_reg[15]} - {9'd0, cad_reg};

    always_comb
    begin
        lvl = (res_reg == 8'd0) ? 5'd0 : ((res_reg > 8'd32) ? 5'd31 : 5'(res_reg - 8'd1));
        s_idx = 4'((16'(cad_reg) * 16'd205) >> 11);
        if (cad_reg >= 8'd100)
        begin
            s_idx = 4'd10;
        end
        c_mod = 4'(cad_reg - 8'(s_idx) * 8'd10);
        t_lo = power_entry(lvl, s_idx);
        t_hi = power_entry(lvl, (s_idx == 4'd10) ? 4'd10 : s_idx + 4'd1);
        num = 19'sd10 * $signed({6'd0, t_lo_reg})
            + ($signed({6'd0, t_hi_reg}) - $signed({6'd0, t_lo_reg})) * $signed({15'd0, c_mod});
        big_prod = 21'(cad_reg) * 21'(t_hi_reg);
        if (cad_reg >= 8'd100)
        begin
            wnum_calc = big_prod + 21'd500;
        end
        else
        begin
            wnum_calc = {3'd0, num[17:0]} + 21'd50;
        end
        big_q = 43'(wnum_reg) * 43'(22'd2147484);
        small_q = 34'(wnum_reg[15:0]) * 34'(17'd83887);
        if (wzero_reg)
        begin
            watts_calc = 11'd0;
        end
        else if (wbig_reg)
        begin
            watts_calc = big_q[41:31];
        end
        else
        begin
            watts_calc = small_q[33:23];
        end
    end

    always_comb
    begin
        pub_item = '0;
        pub_item.frame_kind = kind_reg;
        pub_item.crc_ok = crc_reg;
        pub_item.send_handshake = send_hs_reg;
        if (kind_reg == KIND_TELEM)
        begin
            pub_item.resist_level = res_reg;
            pub_item.cadence_rpm = cad_reg;
            pub_item.speed_mm_s = {head_mem[23], head_mem[24]};
            pub_item.distance_raw = {head_mem[10], head_mem[11]};
            pub_item.energy_tenths = {head_mem[12], head_mem[13]};
            pub_item.heart_bpm = head_mem[18];
            pub_item.crank_count = {head_mem[16], head_mem[17]};
            pub_item.crank_time = crank_acc_reg;
            pub_item.est_watts = watts_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && (count_reg < CNT_W'(HEAD_KEEP)))
        begin
            head_mem[count_reg[HIDX_W-1:0]] <= in_item.in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            xor_reg <= '0;
            tail0_reg <= '0;
            tail1_reg <= '0;
            legacy_reg <= 1'b0;
            hs_done_reg <= 1'b0;
            est_en_reg <= 1'b1;
            crank_acc_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                est_en_reg <= cfg_data;
            end
            if (cmd.take_byte)
            begin
                count_reg <= count_inc;
                if (count_reg != '0)
                begin
                    xor_reg <= xor_reg ^ in_item.in_byte;
                end
                tail0_reg <= tail1_reg;
                tail1_reg <= in_item.in_byte;
            end
            if (cmd.start_finish)
            begin
                if (is_start)
                begin
                    legacy_reg <= 1'b1;
                end
                if (is_ack || is_tel)
                begin
                    hs_done_reg <= 1'b1;
                end
                count_reg <= '0;
                xor_reg <= '0;
                tail0_reg <= '0;
                tail1_reg <= '0;
            end
            if (cmd.calc_step && cad_reg != 8'd0)
            begin
                crank_acc_reg <= crank_acc_reg + quot_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_finish)
        begin
            crc_reg <= (count_reg >= CNT_W'(3)) && ((xor_reg ^ tail1_reg) == 8'h00);
            send_hs_reg <= is_start && (count_reg >= CNT_W'(34)) && !hs_done_reg;
            if (is_start)
            begin
                kind_reg <= (count_reg < CNT_W'(34)) ? KIND_SHORT_STARTUP : KIND_STARTUP;
            end
            else if (is_ack)
            begin
                kind_reg <= KIND_ACK;
            end
            else if (is_tel)
            begin
                kind_reg <= KIND_TELEM;
            end
            else
            begin
                kind_reg <= KIND_IGNORED;
            end
            cad_reg <= head_mem[25];
            res_reg <= head_mem[5];
            rem_reg <= '0;
            quot_reg <= 16'd61440;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step && div_cnt_reg != 5'd16)
        begin
            if (!trial[16])
            begin
                rem_reg <= trial[15:0];
                quot_reg <= {quot_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[14:0], quot_reg[15]};
                quot_reg <= {quot_reg[14:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 5'd1;
        end
        if (cmd.div_step)
        begin
            t_lo_reg <= t_lo;
            t_hi_reg <= t_hi;
            wnum_reg <= wnum_calc;
            wbig_reg <= cad_reg >= 8'd100;
            wzero_reg <= (cad_reg == 8'd0) || ((cad_reg < 8'd100) && (num <= 0));
        end
        if (cmd.calc_step)
        begin
            watts_reg <= est_en_reg ? watts_calc : 11'd0;
        end
        if (cmd.publish)
        begin
            out_reg <= pub_item;
        end
    end

    assign out_item = out_reg;

endmodule

@@ rtl/bike_telemetry_frame_parser.sv @@
// Frame parser for a bike telemetry link. Bytes are taken one per cycle
// while the block is idle; the byte that ends a frame starts a finish
// sequence of a classify step, then for telemetry frames a bit-serial
// divider for the crank time (which ends at once when the cadence is zero),
// during which the table lookup for the watt estimate is staged, a step
// for the watt estimate, and a publish step. Publishing waits until the
// output register is free, and the final byte of a frame is held off while
// an earlier result still waits there.
module bike_telemetry_frame_parser #(
    parameter int MAX_FRAME = btfp_pkg::MAX_FRAME_DEF,
    parameter int HEAD_KEEP = btfp_pkg::HEAD_KEEP_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  btfp_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output btfp_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);
    import btfp_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    btfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd),
        .status   (status)
    );

    btfp_datapath #(
        .MAX_FRAME(MAX_FRAME),
        .HEAD_KEEP(HEAD_KEEP)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_data)
    );

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take_byte, cmd.start_finish, cmd.div_step, cmd.calc_step, cmd.publish}))
        else $error("more than one datapath command");
    a_last_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_byte && in_data.frame_last) |=> cmd.start_finish)
        else $error("frame end not followed by finish");
    a_pub_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid)
        else $error("published item not valid");
`endif

endmodule
